### sv/frgcd_pkg.sv
// Shared constants and helpers for the fraction reduction core.
package frgcd_pkg;

  // Default data width of every numerator, denominator and divisor
  localparam int DATA_WIDTH = 31;

  // Round a bit count up to whole bytes
  function automatic int byte_pad(input int bits);
    int padded;
    padded = ((bits + 7) / 8) * 8;
    return padded;
  endfunction

endpackage

### sv/frgcd_div.sv
// Radix-2 restoring divider shared by the remainder and the final quotients.
module frgcd_div #(
  parameter int WIDTH = frgcd_pkg::DATA_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quot,
  output logic [WIDTH-1:0] rem
);

  localparam int CW = $clog2(WIDTH);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem_q;
  logic [WIDTH-1:0] dvsr;

  logic [WIDTH:0] shifted;
  logic [WIDTH:0] diff;
  logic           fits;

  // Trial subtract of the divisor from the partial remainder
  assign shifted = {rem_q, quo[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvsr};
  assign fits    = (shifted >= {1'b0, dvsr});

  // Control: start loads, one quotient bit per cycle, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend out and quotient bits in
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo   <= dividend;
      rem_q <= '0;
      dvsr  <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem_q <= diff[WIDTH-1:0];
        quo   <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem_q <= shifted[WIDTH-1:0];
        quo   <= {quo[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quot = quo;
  assign rem  = rem_q;

endmodule

### sv/fraction_reduce_gcd_core.sv
// Fraction reduction core: Euclid GCD and exact division on one shared divider.
// Reduces numerator/denominator to lowest terms and returns the reduced pair
// with their greatest common divisor. A zero numerator gives 0/1 with the
// divisor equal to the denominator; a zero denominator is taken as 1. One
// transaction is in work at a time: the input is ready only while the
// sequencer is idle, and a finished result waits in an output register so
// the next transaction can be taken before it is read. All arithmetic runs
// on one bit-serial restoring divider that retires one quotient bit per
// cycle; the number of Euclid remainder steps is at most about 1.44*WIDTH
// and typically a handful.
module fraction_reduce_gcd_core #(
  parameter int WIDTH = frgcd_pkg::DATA_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // fields from bit 0: numer_in, denom_in
  input  logic [frgcd_pkg::byte_pad(2*WIDTH)-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // fields from bit 0: numer_out, denom_out, common_divisor
  output logic [frgcd_pkg::byte_pad(3*WIDTH)-1:0] m_tdata
);

  localparam int OUT_TW = frgcd_pkg::byte_pad(3*WIDTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_REM   = 3'd2;
  localparam logic [2:0] S_QN    = 3'd3;
  localparam logic [2:0] S_QD    = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;
  logic [WIDTH-1:0] numer;
  logic [WIDTH-1:0] denom;
  logic [WIDTH-1:0] big;
  logic [WIDTH-1:0] small_val;
  logic [WIDTH-1:0] qn;
  logic [WIDTH-1:0] qd;
  logic [WIDTH-1:0] numer_out;
  logic [WIDTH-1:0] denom_out;
  logic [WIDTH-1:0] common_divisor;

  logic [WIDTH-1:0] in_n;
  logic [WIDTH-1:0] in_d;

  logic             div_start;
  logic [WIDTH-1:0] div_dividend;
  logic [WIDTH-1:0] div_divisor;
  logic             div_done;
  logic [WIDTH-1:0] div_quot;
  logic [WIDTH-1:0] div_rem;

  // Unpack input, force a zero denominator to one
  assign in_n = s_tdata[WIDTH-1:0];
  assign in_d = (s_tdata[2*WIDTH-1:WIDTH] == '0) ? WIDTH'(1) : s_tdata[2*WIDTH-1:WIDTH];

  assign s_tready = (state == S_IDLE);

  // Pick divider operands for the current phase
  always_comb begin
    div_start    = 1'b0;
    div_dividend = big;
    div_divisor  = small_val;
    unique case (state)
      S_CHECK: begin
        div_start = 1'b1;
        if (small_val == '0) begin
          div_dividend = numer;
          div_divisor  = big;
        end
      end
      S_QN: begin
        div_start    = div_done;
        div_dividend = denom;
        div_divisor  = big;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  frgcd_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  // Sequencer: Euclid loop, then the two exact quotients
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // Drop a taken result unless the output phase replaces it
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (small_val == '0) ? S_QN : S_REM;
        end
        S_REM: begin
          if (div_done) begin
            state <= S_CHECK;
          end
        end
        S_QN: begin
          if (div_done) begin
            state <= S_QD;
          end
        end
        S_QD: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      numer     <= in_n;
      denom     <= in_d;
      big       <= (in_n > in_d) ? in_n : in_d;
      small_val <= (in_n > in_d) ? in_d : in_n;
    end
    if (state == S_REM && div_done) begin
      big       <= small_val;
      small_val <= div_rem;
    end
    if (state == S_QN && div_done) begin
      qn <= div_quot;
    end
    if (state == S_QD && div_done) begin
      qd <= div_quot;
    end
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      numer_out      <= qn;
      denom_out      <= qd;
      common_divisor <= big;
    end
  end

  assign m_tdata = OUT_TW'({common_divisor, denom_out, numer_out});

  // A presented result never carries a zero divisor or denominator
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> common_divisor != '0)
    else $error("zero common divisor presented");

  a_denom_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> denom_out != '0)
    else $error("zero reduced denominator presented");

  // Every check launches the divider into a wait phase
  a_check_next: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |=> state == S_REM || state == S_QN)
    else $error("check phase did not start a division");

  // A new result appears only from the output phase
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT)
    else $error("result raised outside output phase");

endmodule

### test/fraction_reduce_gcd_core_tb.sv
// Testbench for the fraction reduction core: stream stimulus, GCD predictor, result checker.
`timescale 1ns / 1ps

module fraction_reduce_gcd_core_tb;

  localparam int W = frgcd_pkg::DATA_WIDTH;
  localparam int S_BITS = frgcd_pkg::byte_pad(2*W);
  localparam int M_BITS = frgcd_pkg::byte_pad(3*W);
  localparam int DRAIN_CYCLES = 2000;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    word_t numer;
    word_t denom;
    word_t divisor;
  } reduced_frac_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [S_BITS-1:0] s_tdata;   // from bit 0: numer_in, denom_in
  logic              m_tvalid;
  logic              m_tready;
  logic [M_BITS-1:0] m_tdata;   // from bit 0: numer_out, denom_out, common_divisor

  reduced_frac_t pending_reductions[$];
  int            n_sent;
  int            n_checked;
  int            n_reducible;
  int            n_errors;
  bit            idle_enable;

  fraction_reduce_gcd_core #(
    .WIDTH(W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run time
  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Reduce n/d to lowest terms; a zero denominator counts as one
  function automatic reduced_frac_t reduce_fraction(word_t n, word_t d);
    reduced_frac_t res;
    word_t hi;
    word_t lo;
    word_t rem;
    if (d == '0) d = word_t'(1);
    hi = (n > d) ? n : d;
    lo = (n > d) ? d : n;
    while (lo != '0) begin
      rem = hi % lo;
      hi  = lo;
      lo  = rem;
    end
    if (hi == '0) hi = word_t'(1);
    res.numer   = n / hi;
    res.denom   = d / hi;
    res.divisor = hi;
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic word_t rand_word();
    return word_t'($urandom);
  endfunction

  // Offer one fraction; return at the falling edge after the transaction
  task automatic send_fraction(input word_t numer, input word_t denom);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_BITS-2*W){1'b0}}, denom, numer};
    do @(posedge clk); while (!s_tready);
    pending_reductions.push_back(reduce_fraction(numer, denom));
    n_sent++;
    @(negedge clk);
  endtask

  // Stall the result side at random
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // Compare each result transaction with the oldest expected reduction
  always @(posedge clk) begin
    reduced_frac_t want;
    reduced_frac_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.numer   = m_tdata[W-1:0];
      got.denom   = m_tdata[2*W-1:W];
      got.divisor = m_tdata[3*W-1:2*W];
      if (pending_reductions.size() == 0) begin
        $error("unexpected result: numer_out %0d denom_out %0d common_divisor %0d",
               got.numer, got.denom, got.divisor);
        n_errors++;
      end else begin
        want = pending_reductions.pop_front();
        n_checked++;
        if (want.divisor > 1) n_reducible++;
        if (got.numer !== want.numer) begin
          $error("numer_out: expected %0d, got %0d", want.numer, got.numer);
          n_errors++;
        end
        if (got.denom !== want.denom) begin
          $error("denom_out: expected %0d, got %0d", want.denom, got.denom);
          n_errors++;
        end
        if (got.divisor !== want.divisor) begin
          $error("common_divisor: expected %0d, got %0d", want.divisor, got.divisor);
          n_errors++;
        end
      end
    end
  end

  // Extremes, zero terms and the slowest Euclid pairs
  task automatic test_directed();
    word_t max_w;
    max_w = '1;
    send_fraction(word_t'(0), word_t'(1));
    send_fraction(word_t'(0), max_w);
    send_fraction(word_t'(0), word_t'(12));
    send_fraction(max_w, max_w);
    send_fraction(max_w, word_t'(1));
    send_fraction(word_t'(1), max_w);
    send_fraction(word_t'(1), word_t'(1));
    send_fraction(word_t'(5), word_t'(0));
    send_fraction(word_t'(0), word_t'(0));
    send_fraction(max_w, word_t'(0));
    send_fraction(word_t'(1836311903), word_t'(1134903170));
    send_fraction(word_t'(1134903170), word_t'(1836311903));
    send_fraction(word_t'(12), word_t'(18));
    send_fraction(word_t'(18), word_t'(12));
    send_fraction(word_t'(1 << (W-1)), word_t'(1 << 10));
    send_fraction(word_t'(1 << 3), word_t'(1 << (W-1)));
    send_fraction(word_t'(2147483629), word_t'(2147483587));
    send_fraction(word_t'(1000000), word_t'(1000));
    send_fraction(word_t'(7), word_t'(7 * 306783378));
    send_fraction(word_t'(31'h2AAAAAAA), word_t'(31'h55555555));
  endtask

  // Full-range values, mostly coprime, with an occasional zero numerator
  task automatic test_random_full(input int count);
    word_t n;
    word_t d;
    repeat (count) begin
      n = ($urandom_range(0, 31) == 0) ? word_t'(0) : rand_word();
      d = rand_word();
      if (d == '0) d = word_t'(1);
      send_fraction(n, d);
    end
  endtask

  // Both terms built from a random common factor
  task automatic test_shared_factor(input int count);
    int               gb;
    longint unsigned  g;
    longint unsigned  a;
    longint unsigned  b;
    repeat (count) begin
      gb = $urandom_range(1, W-2);
      g  = 64'($urandom_range(1, (1 << gb) - 1));
      a  = 64'($urandom_range(0, (1 << (W-gb)) - 1));
      b  = 64'($urandom_range(1, (1 << (W-gb)) - 1));
      send_fraction(word_t'(g * a), word_t'(g * b));
    end
  endtask

  // Small terms, zero denominator included
  task automatic test_small_values(input int count);
    repeat (count) begin
      send_fraction(word_t'($urandom_range(0, 255)), word_t'($urandom_range(0, 255)));
    end
  endtask

  // Consecutive Fibonacci pairs: the most remainder steps for their size
  task automatic test_fibonacci(input int count);
    longint unsigned fa;
    longint unsigned fb;
    longint unsigned t;
    int              k;
    repeat (count) begin
      fa = 64'd1;
      fb = 64'd1;
      k  = $urandom_range(1, 44);
      repeat (k) begin
        t  = fa + fb;
        fa = fb;
        fb = t;
      end
      if ($urandom_range(0, 1) != 0) send_fraction(word_t'(fa), word_t'(fb));
      else send_fraction(word_t'(fb), word_t'(fa));
    end
  endtask

  // Full rate on both sides: no idle cycles at all
  task automatic test_back_to_back(input int count);
    idle_enable = 1'b0;
    test_random_full(count / 2);
    test_shared_factor(count - count / 2);
    idle_enable = 1'b1;
  endtask

  // Main sequence
  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    n_sent      = 0;
    n_checked   = 0;
    n_reducible = 0;
    n_errors    = 0;
    idle_enable = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random_full(600);
    test_shared_factor(500);
    test_small_values(300);
    test_fibonacci(60);
    test_back_to_back(70);
    s_tvalid <= 1'b0;

    // Drain outstanding results, then watch for stray ones
    while (pending_reductions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d fractions sent, %0d results checked, %0d with a divisor above one",
             n_sent, n_checked, n_reducible);
    $display("Covered zero terms, full-range, shared-factor, small and Fibonacci operands");
    if (n_errors == 0 && pending_reductions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
